>>> sv/sharpen_3x3_stream_top_assert.svh
// Assertion macros for the checker file of the sharpen block.
// SHRP3_ASSERT_RUN expects signals named clk and rst in the scope of use; SHRP3_ASSERT_ANY needs only clk.
`ifndef SHARPEN_3X3_STREAM_TOP_ASSERT_SVH
`define SHARPEN_3X3_STREAM_TOP_ASSERT_SVH

// Checked only while reset is low.
`define SHRP3_ASSERT_RUN(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define SHRP3_ASSERT_ANY(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/shrp3_pkg.sv
package shrp3_pkg;

  localparam int MAX_WIDTH_DEFAULT    = 4096;
  localparam int MAX_CHANNELS_DEFAULT = 4;
  localparam int MAX_HEIGHT           = 4096;

  localparam int SAMPLE_W    = 8;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_INDEX_W = 2;
  localparam int CHAN_W      = 3;
  localparam int ROW_W       = 12;

  localparam logic [CFG_DATA_W-1:0] WIDTH_RESET    = 13'd640;
  localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET   = 13'd480;
  localparam logic [CHAN_W-1:0]     CHANNELS_RESET = 3'd3;
  localparam logic [CFG_DATA_W-1:0] DIM_MIN        = 13'd3;
  localparam logic [CHAN_W-1:0]     CHAN_MIN       = 3'd1;

  localparam int CENTRE_GAIN = 5;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_WIDTH    = 2'd0,
    CFG_HEIGHT   = 2'd1,
    CFG_CHANNELS = 2'd2
  } cfg_index_t;

  // One result as it leaves the block.
  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic                last;
  } result_t;

  // Up to two results handed to the output queue in one cycle.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } result_pair_t;

endpackage

>>> sv/sharpen_3x3_stream_top.sv
// Channel | Dir | Handshake                     | Payload
// --------+-----+-------------------------------+------------------------------------------
// s_axis  | in  | s_axis_tvalid, s_axis_tready  | tdata[7:0] sample
// m_axis  | out | m_axis_tvalid, m_axis_tready  | tdata[7:0] sharp_value, tlast run_last
// cfg     | in  | cfg_we                        | cfg_index 0 width, 1 height, 2 chans; cfg_data
//
// The block takes one sample per clock cycle while the result queue has room. The results
// of a sample pass through the compute stage register and the result queue to m_axis. Rows that
// give two results per sample are limited to one result per cycle by the output port, so
// there the input is held back to keep pace with the output.
// Reset (synchronous, active high) clears counters and queues and loads the default
// configuration; the line stores are not cleared and need no clearing pass. A stall on
// m_axis backs up through the four-entry result queue and the compute stage to s_axis_tready.
module sharpen_3x3_stream_top
  import shrp3_pkg::*;
#(
  parameter int MAX_WIDTH    = MAX_WIDTH_DEFAULT,
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [SAMPLE_W-1:0]    s_axis_tdata,   // [7:0] sample
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [SAMPLE_W-1:0]    m_axis_tdata,   // [7:0] sharp_value
  output logic                   m_axis_tlast,   // run_last
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int STORE_DEPTH = MAX_WIDTH * MAX_CHANNELS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int LEN_W       = ADDR_W + 1;
  localparam int TAPS        = 2 * MAX_CHANNELS;
  localparam int TAP_W       = (TAPS > 2) ? $clog2(TAPS) : 1;

  // The width register is 13 bits wide, so a larger store size never clamps it.
  localparam logic [CFG_DATA_W-1:0] WIDTH_CAP =
      (MAX_WIDTH > 8191) ? 13'h1FFF : 13'(MAX_WIDTH);
  localparam logic [CFG_DATA_W-1:0] HEIGHT_CAP = 13'(MAX_HEIGHT);
  localparam logic [CHAN_W-1:0]     CHAN_CAP   = 3'(MAX_CHANNELS);

  // Configuration and frame position.
  logic [CFG_DATA_W-1:0] image_width;
  logic [CFG_DATA_W-1:0] image_height;
  logic [CHAN_W-1:0]     channel_count;
  logic [ADDR_W-1:0]     sample_counter;
  logic [ROW_W-1:0]      row_counter;

  logic [CFG_DATA_W-1:0] width_eff;
  logic [CFG_DATA_W-1:0] height_eff;
  logic [CHAN_W-1:0]     chan_eff;
  logic [15:0]           len_prod;
  logic [LEN_W-1:0]      row_len;
  logic [ADDR_W-1:0]     pos;
  logic [ROW_W-1:0]      row;
  logic [LEN_W-1:0]      pos_ext;
  logic [LEN_W-1:0]      chan_ext;
  logic [LEN_W-1:0]      right_sum;
  logic [ADDR_W-1:0]     right_addr;
  logic                  interior;
  logic                  last_row;
  logic                  pos_last;
  logic                  in_fire;
  logic                  cfg_hit;

  // History of values read from the newer store; tap 0 is the latest read.
  logic [SAMPLE_W-1:0] rd_right;
  logic [SAMPLE_W-1:0] rd_up;
  logic [SAMPLE_W-1:0] hist [TAPS-1];
  logic [SAMPLE_W-1:0] tap  [TAPS];
  logic [TAP_W-1:0]    centre_idx;
  logic [TAP_W-1:0]    left_idx;
  logic [3:0]          left_off;
  logic [SAMPLE_W-1:0] centre_now;

  // Compute stage.
  logic                s1_valid;
  logic                s1_valid_next;
  logic [SAMPLE_W-1:0] s1_centre;
  logic [SAMPLE_W-1:0] s1_left;
  logic [SAMPLE_W-1:0] s1_down;
  logic                s1_interior;
  logic                s1_main;
  logic                s1_zero;
  logic                s1_move;
  logic [10:0]         gain_term;
  logic [9:0]          neg_term;
  logic signed [11:0]  diff;
  logic [SAMPLE_W-1:0] sat_value;
  logic [SAMPLE_W-1:0] sharp;

  result_pair_t pair;
  result_t      head;
  logic         room;

  // Effective dimensions: registers are clamped to their meaningful ranges.
  always_comb begin
    if (image_width < DIM_MIN) begin
      width_eff = DIM_MIN;
    end else if (image_width > WIDTH_CAP) begin
      width_eff = WIDTH_CAP;
    end else begin
      width_eff = image_width;
    end
    if (image_height < DIM_MIN) begin
      height_eff = DIM_MIN;
    end else if (image_height > HEIGHT_CAP) begin
      height_eff = HEIGHT_CAP;
    end else begin
      height_eff = image_height;
    end
    if (channel_count < CHAN_MIN) begin
      chan_eff = CHAN_MIN;
    end else if (channel_count > CHAN_CAP) begin
      chan_eff = CHAN_CAP;
    end else begin
      chan_eff = channel_count;
    end
  end

  assign len_prod = {3'b000, width_eff} * {13'd0, chan_eff};
  assign row_len  = LEN_W'(len_prod);

  // A configuration write to width, height or channels restarts the frame, so these guards
  // only matter as a safety net against a position left over from larger dimensions.
  assign pos = ({1'b0, sample_counter} >= row_len) ? '0 : sample_counter;
  assign row = ({1'b0, row_counter} >= height_eff) ? '0 : row_counter;

  assign pos_ext   = {1'b0, pos};
  assign chan_ext  = LEN_W'(chan_eff);
  assign right_sum = pos_ext + chan_ext;

  // The right neighbour read wraps into the start of the row. The sample read at
  // the wrapped position is the one the next row needs as its centre, so the
  // history below stays correct across row ends.
  assign right_addr = ADDR_W'((right_sum >= row_len) ? right_sum - row_len : right_sum);

  // Interior means row at least two (the result row is row - 1), and a pixel that
  // has a neighbour on both sides.
  assign interior = (row >= ROW_W'(2)) && (pos_ext >= chan_ext) && (right_sum < row_len);
  assign last_row = {1'b0, row} == height_eff - 13'd1;
  assign pos_last = (pos_ext + LEN_W'(1)) >= row_len;

  // The centre of the current position was read as a right neighbour one pixel
  // earlier; the left neighbour was read two pixels earlier.
  always_comb begin
    tap[0] = rd_right;
    for (int i = 1; i < TAPS; i++) begin
      tap[i] = hist[i-1];
    end
  end

  assign left_off   = {1'b0, chan_eff} + {1'b0, chan_eff} - 4'd1;
  assign centre_idx = TAP_W'(chan_eff - CHAN_MIN);
  assign left_idx   = TAP_W'(left_off);
  assign centre_now = tap[centre_idx];

  assign s_axis_tready = !s1_valid || room;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign s1_move       = s1_valid && room;

  // The newer store takes the incoming sample; the older store takes what the
  // newer store held at the same position.
  shrp3_line_mem #(
    .DEPTH (STORE_DEPTH)
  ) u_newer (
    .clk     (clk),
    .wr_en   (in_fire),
    .wr_addr (pos),
    .wr_data (s_axis_tdata),
    .rd_en   (in_fire),
    .rd_addr (right_addr),
    .rd_data (rd_right)
  );

  shrp3_line_mem #(
    .DEPTH (STORE_DEPTH)
  ) u_older (
    .clk     (clk),
    .wr_en   (in_fire),
    .wr_addr (pos),
    .wr_data (centre_now),
    .rd_en   (in_fire),
    .rd_addr (pos),
    .rd_data (rd_up)
  );

  always_ff @(posedge clk) begin
    if (in_fire) begin
      hist[0] <= rd_right;
      for (int i = 1; i < TAPS - 1; i++) begin
        hist[i] <= hist[i-1];
      end
      s1_centre   <= centre_now;
      s1_left     <= tap[left_idx];
      s1_down     <= s_axis_tdata;
      s1_interior <= interior;
      s1_main     <= row != '0;
      s1_zero     <= last_row;
    end
  end

  assign cfg_hit = cfg_we && (cfg_index == CFG_WIDTH || cfg_index == CFG_HEIGHT ||
                              cfg_index == CFG_CHANNELS);

  always_comb begin
    s1_valid_next = s1_valid;
    if (in_fire) begin
      s1_valid_next = 1'b1;
    end else if (s1_move) begin
      s1_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= WIDTH_RESET;
      image_height   <= HEIGHT_RESET;
      channel_count  <= CHANNELS_RESET;
      sample_counter <= '0;
      row_counter    <= '0;
      s1_valid       <= 1'b0;
    end else begin
      s1_valid <= s1_valid_next;
      if (cfg_we) begin
        case (cfg_index)
          CFG_WIDTH: begin
            image_width <= cfg_data;
          end
          CFG_HEIGHT: begin
            image_height <= cfg_data;
          end
          CFG_CHANNELS: begin
            channel_count <= cfg_data[CHAN_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (cfg_hit) begin
        sample_counter <= '0;
        row_counter    <= '0;
      end else if (in_fire) begin
        if (pos_last) begin
          sample_counter <= '0;
          row_counter    <= last_row ? '0 : row + ROW_W'(1);
        end else begin
          sample_counter <= pos + ADDR_W'(1);
          row_counter    <= row;
        end
      end
    end
  end

  // 5 * centre minus the four neighbours, then saturation to eight bits.
  assign gain_term = 11'(s1_centre) * 11'(CENTRE_GAIN);
  assign neg_term  = 10'(s1_left) + 10'(rd_right) + 10'(rd_up) + 10'(s1_down);
  assign diff      = $signed({1'b0, gain_term}) - $signed({2'b00, neg_term});

  always_comb begin
    if (diff[11]) begin
      sat_value = '0;
    end else if (diff[10:8] != 3'd0) begin
      sat_value = '1;
    end else begin
      sat_value = diff[7:0];
    end
  end

  assign sharp = s1_interior ? sat_value : '0;

  // The row above comes first; on the last row its own zero follows and carries
  // the run mark.
  always_comb begin
    pair.count        = s1_move ? (2'(s1_main) + 2'(s1_zero)) : 2'd0;
    pair.second.value = '0;
    pair.second.last  = 1'b1;
    if (s1_main) begin
      pair.first.value = sharp;
      pair.first.last  = !s1_zero;
    end else begin
      pair.first.value = '0;
      pair.first.last  = 1'b1;
    end
  end

  shrp3_result_fifo u_results (
    .clk        (clk),
    .rst        (rst),
    .push       (pair),
    .room       (room),
    .head_valid (m_axis_tvalid),
    .head       (head),
    .pop        (m_axis_tready)
  );

  assign m_axis_tdata = head.value;
  assign m_axis_tlast = head.last;

endmodule

>>> sv/shrp3_line_mem.sv
module shrp3_line_mem
  import shrp3_pkg::*;
#(
  parameter int DEPTH = MAX_WIDTH_DEFAULT * MAX_CHANNELS_DEFAULT,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  logic [SAMPLE_W-1:0] wr_data,
  input  logic                rd_en,
  input  logic [ADDR_W-1:0]   rd_addr,
  output logic [SAMPLE_W-1:0] rd_data
);

  logic [SAMPLE_W-1:0] mem [DEPTH];

  // Read returns the contents from before a write in the same cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> sv/shrp3_result_fifo.sv
module shrp3_result_fifo
  import shrp3_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  result_pair_t push,
  output logic         room,
  output logic         head_valid,
  output result_t      head,
  input  logic         pop
);

  localparam int DEPTH   = 4;
  localparam int PTR_W   = $clog2(DEPTH);
  localparam int COUNT_W = PTR_W + 1;

  result_t            slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [COUNT_W-1:0] count;
  logic               pop_fire;

  // Room for a full pair regardless of what is popped this cycle.
  assign room       = count <= COUNT_W'(DEPTH - 2);
  assign head_valid = count != '0;
  assign head       = slots[rd_ptr];
  assign pop_fire   = pop & head_valid;

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      slots[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      slots[wr_ptr + PTR_W'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push.count);
      rd_ptr <= rd_ptr + PTR_W'(pop_fire);
      count  <= count + COUNT_W'(push.count) - COUNT_W'(pop_fire);
    end
  end

endmodule

>>> sv/shrp3_port_chk.sv
module shrp3_port_chk
  import shrp3_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [SAMPLE_W-1:0] m_axis_tdata,
  input logic                m_axis_tlast
);

`include "sharpen_3x3_stream_top_assert.svh"

  // Nothing is queued right after reset.
  `SHRP3_ASSERT_ANY(a_no_result_after_reset, rst |=> !m_axis_tvalid, "result valid after reset")

  // The compute stage is empty after reset, so input is taken at once.
  `SHRP3_ASSERT_ANY(a_ready_after_reset, rst |=> s_axis_tready, "input not ready after reset")

  // With the result queue empty, nothing can hold the input back.
  `SHRP3_ASSERT_RUN(a_ready_when_drained, !m_axis_tvalid |-> s_axis_tready, "stall while drained")

  `SHRP3_ASSERT_RUN(a_result_holds,
                    m_axis_tvalid && !m_axis_tready |=>
                    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast),
                    "result changed while stalled")

endmodule

bind sharpen_3x3_stream_top shrp3_port_chk u_port_chk (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
